// File: design/lsft_pkg.sv
package lsft_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int NUM_PORTS   = 8;

  localparam int MAC_W  = 48;
  localparam int PORT_W = 3;
  localparam int MASK_W = 8;
  localparam int IDX_W  = $clog2(TABLE_DEPTH);
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

  localparam int QUEUE_DEPTH = 2;
  localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Ports at or above NUM_PORTS have no bit in the egress mask.
  localparam logic [MASK_W-1:0] PORT_RANGE_MASK =
    (NUM_PORTS >= MASK_W) ? {MASK_W{1'b1}} : MASK_W'((1 << NUM_PORTS) - 1);

  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_LOAD  = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [PORT_W-1:0] arrival_port;
    logic [MAC_W-1:0]  src_mac;
    logic [MAC_W-1:0]  dst_mac;
    logic [MAC_W-1:0]  static_mac;
    logic [PORT_W-1:0] static_port;
  } in_item_t;

  typedef struct packed {
    logic [MASK_W-1:0] egress_mask;
    logic              flooded;
    logic              table_full;
  } out_item_t;

  // Command handed from the front end to the table engine.
  typedef struct packed {
    logic              kind;
    logic [MAC_W-1:0]  learn_mac;
    logic [PORT_W-1:0] learn_port;
    logic [MAC_W-1:0]  dst_mac;
    logic [PORT_W-1:0] arrival_port;
  } cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] entry_count;
    logic             busy;
  } status_t;

endpackage

// File: design/lsft_front.sv
module lsft_front
  import lsft_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output logic     push_valid,
  input  logic     push_ready,
  output cmd_t     push_data
);

  logic valid_r;
  cmd_t cmd_r;
  cmd_t cmd_nxt;

  assign in_ready   = !valid_r || push_ready;
  assign push_valid = valid_r;
  assign push_data  = cmd_r;

  // A static load learns its own address and port; a frame learns its source.
  always_comb begin
    cmd_nxt.kind         = in_data.kind;
    cmd_nxt.dst_mac      = in_data.dst_mac;
    cmd_nxt.arrival_port = in_data.arrival_port;
    if (in_data.kind == KIND_LOAD) begin
      cmd_nxt.learn_mac  = in_data.static_mac;
      cmd_nxt.learn_port = in_data.static_port;
    end else begin
      cmd_nxt.learn_mac  = in_data.src_mac;
      cmd_nxt.learn_port = in_data.arrival_port;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid_r <= 1'b1;
    end else if (push_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r <= cmd_nxt;
    end
  end

endmodule

// File: design/lsft_fifo.sv
module lsft_fifo
  import lsft_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_data
);

  cmd_t              slot_r [QUEUE_DEPTH];
  logic [QIDX_W-1:0] wr_ptr_r;
  logic [QIDX_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] fill_r;
  logic              do_push;
  logic              do_pop;

  assign push_ready = fill_r != QCNT_W'(QUEUE_DEPTH);
  assign pop_valid  = fill_r != '0;
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  function automatic logic [QIDX_W-1:0] ptr_inc(input logic [QIDX_W-1:0] p);
    if (p == QIDX_W'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (do_push && !do_pop) begin
        fill_r <= fill_r + 1'b1;
      end else if (do_pop && !do_push) begin
        fill_r <= fill_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: design/lsft_back.sv
module lsft_back
  import lsft_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      pop_valid,
  output logic      pop_ready,
  input  cmd_t      pop_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  output status_t   status
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_LEARN = 2'd1;
  localparam logic [1:0] ST_LOOK  = 2'd2;
  localparam logic [1:0] ST_SEL   = 2'd3;

  logic [1:0]       state_r;
  logic [1:0]       state_nxt;
  cmd_t             cmd_r;
  logic             full_r;
  logic [CNT_W-1:0] count_r;

  logic [MAC_W-1:0]  mac_r    [TABLE_DEPTH];
  logic [PORT_W-1:0] port_r   [TABLE_DEPTH];
  logic              static_r [TABLE_DEPTH];

  logic [TABLE_DEPTH-1:0] hit_r;
  logic [TABLE_DEPTH-1:0] src_match;
  logic [TABLE_DEPTH-1:0] dst_match;
  logic [TABLE_DEPTH-1:0] first_hit;
  logic [PORT_W-1:0]      hit_port;

  logic      out_valid_r;
  out_item_t out_data_r;
  out_item_t result;

  logic is_frame;
  logic src_known;
  logic room;
  logic need_append;
  logic app_en;
  logic out_free;
  logic finish;
  logic take;

  assign is_frame    = cmd_r.kind == KIND_FRAME;
  assign src_known   = |src_match;
  assign room        = count_r < CNT_W'(TABLE_DEPTH);
  assign need_append = (state_r == ST_LEARN) && (!is_frame || !src_known);
  assign app_en      = need_append && room;
  assign out_free    = !out_valid_r || out_ready;
  assign finish      = (state_r == ST_SEL) && out_free;
  assign pop_ready   = (state_r == ST_IDLE) || finish;
  assign take        = pop_valid && pop_ready;

  assign out_valid          = out_valid_r;
  assign out_data           = out_data_r;
  assign status.entry_count = count_r;
  assign status.busy        = state_r != ST_IDLE;

  // Each entry compares itself against both addresses; only filled entries count.
  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      src_match[i] = (CNT_W'(i) < count_r) && (mac_r[i] == cmd_r.learn_mac);
      dst_match[i] = (CNT_W'(i) < count_r) && (mac_r[i] == cmd_r.dst_mac);
    end
  end

  // The lowest set bit of the hit vector is the earliest inserted match.
  assign first_hit = hit_r & (~hit_r + TABLE_DEPTH'(1));

  always_comb begin
    hit_port = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      hit_port = hit_port | ({PORT_W{first_hit[i]}} & port_r[i]);
    end
  end

  always_comb begin
    result.table_full = full_r;
    if (!is_frame) begin
      result.egress_mask = '0;
      result.flooded     = 1'b0;
    end else if (|hit_r) begin
      result.egress_mask = (MASK_W'(1) << hit_port) & PORT_RANGE_MASK;
      result.flooded     = 1'b0;
    end else begin
      result.egress_mask = PORT_RANGE_MASK & ~(MASK_W'(1) << cmd_r.arrival_port);
      result.flooded     = 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (pop_valid) begin
          state_nxt = ST_LEARN;
        end
      end
      ST_LEARN: begin
        state_nxt = is_frame ? ST_LOOK : ST_SEL;
      end
      ST_LOOK: begin
        state_nxt = ST_SEL;
      end
      ST_SEL: begin
        if (finish) begin
          state_nxt = pop_valid ? ST_LEARN : ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (app_en) begin
        count_r <= count_r + 1'b1;
      end
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cmd_r <= pop_data;
    end
    if (state_r == ST_LEARN) begin
      full_r <= need_append && !room;
    end
    if (state_r == ST_LOOK) begin
      hit_r <= dst_match;
    end
    if (finish) begin
      out_data_r <= result;
    end
  end

  // A learned source moves every matching dynamic entry; an append fills the next slot.
  always_ff @(posedge clk) begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (app_en && (count_r[IDX_W-1:0] == IDX_W'(i))) begin
        mac_r[i]    <= cmd_r.learn_mac;
        port_r[i]   <= cmd_r.learn_port;
        static_r[i] <= !is_frame;
      end else if ((state_r == ST_LEARN) && is_frame && src_match[i] && !static_r[i]) begin
        port_r[i] <= cmd_r.arrival_port;
      end
    end
  end

endmodule

// File: design/learning_switch_forwarding_table_unit.sv
// Learning bridge forwarding table with up to TABLE_DEPTH MAC entries held in
// insertion order. Each transaction is either a frame (learn the source, then
// look up the destination) or a static entry load, and produces exactly one
// result: for a frame, a one-hot egress mask on a hit or a flood mask without
// the arrival port on a miss, an empty mask for a static load, and a table_full
// flag when an append had no room. The table is a row of compare cells searched
// in parallel, and that one search array is shared by learning and lookup, so
// the engine takes a frame through source compare and update, destination
// compare and first-match select, and a load through learning and select, with
// the next transaction starting as a result is written. An input register and
// a two-entry queue in front of the engine let input transactions be accepted
// while engine or output is stalled; no clearing pass is needed after reset.
module learning_switch_forwarding_table_unit
  import lsft_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic    push_valid;
  logic    push_ready;
  cmd_t    push_data;
  logic    pop_valid;
  logic    pop_ready;
  cmd_t    pop_data;
  status_t status;

  lsft_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  lsft_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  lsft_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .status    (status)
  );

  // The table only grows, and by at most one entry per cycle.
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (status.entry_count == $past(status.entry_count)) ||
                     (status.entry_count == CNT_W'($past(status.entry_count) + 1'b1)))
    else $error("entry count moved by more than one or shrank");

  a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.table_full |-> status.entry_count == CNT_W'(TABLE_DEPTH))
    else $error("table_full reported while the table has room");

  a_hit_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.flooded |-> $onehot0(out_data.egress_mask))
    else $error("a hit produced more than one egress port");

  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !status.busy && pop_valid |=> status.busy)
    else $error("queued transaction not picked up by an idle engine");

endmodule
